// ----- sv/actuator_frame_serializer_crc16_core_assert.svh -----
// Assertion macros used by the checker file of this block.
// Each macro expands to one labeled concurrent assertion.
`ifndef ACTUATOR_FRAME_SERIALIZER_CRC16_CORE_ASSERT_SVH
`define ACTUATOR_FRAME_SERIALIZER_CRC16_CORE_ASSERT_SVH

// Implication into the next cycle, disabled while reset is asserted.
`define AFS_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("afs assertion failed");

// Implication into the next cycle that is also checked during reset.
`define AFS_ASSERT_NEXT_ALWAYS(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("afs assertion failed");

`endif

// ----- sv/afs_pkg.sv -----
// ----------------------------------------------------------------------------
// afs_pkg
// Types, constants and the CRC-16/MCRF4XX byte update shared by the actuator
// frame serializer.
// ----------------------------------------------------------------------------
package afs_pkg;

  localparam logic       CMD_BEGIN   = 1'b0;
  localparam logic       CMD_CONTROL = 1'b1;

  localparam logic [1:0] REG_SYSTEM_ID    = 2'd0;
  localparam logic [1:0] REG_COMPONENT_ID = 2'd1;
  localparam logic [1:0] REG_MESSAGE_ID   = 2'd2;

  localparam logic [7:0]  FRAME_MAGIC = 8'hFD;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;

  localparam logic [7:0]  SYSTEM_ID_RESET    = 8'd1;
  localparam logic [7:0]  COMPONENT_ID_RESET = 8'd1;
  localparam logic [23:0] MESSAGE_ID_RESET   = 24'd93;

  // Byte positions inside each section of the frame.
  localparam logic [4:0] HEAD_MAGIC    = 5'd0;
  localparam logic [4:0] HEAD_LEN      = 5'd1;
  localparam logic [4:0] HEAD_FLAG0    = 5'd2;
  localparam logic [4:0] HEAD_FLAG1    = 5'd3;
  localparam logic [4:0] HEAD_SEQ      = 5'd4;
  localparam logic [4:0] HEAD_SYS      = 5'd5;
  localparam logic [4:0] HEAD_COMP     = 5'd6;
  localparam logic [4:0] HEAD_MSG0     = 5'd7;
  localparam logic [4:0] HEAD_MSG1     = 5'd8;
  localparam logic [4:0] HEAD_MSG2     = 5'd9;
  localparam logic [4:0] HEAD_TIME     = 5'd10;
  localparam logic [4:0] HEAD_LAST     = 5'd17;
  localparam logic [4:0] CTRL_LAST     = 5'd3;
  localparam logic [4:0] TAIL_MODE     = 5'd0;
  localparam logic [4:0] TAIL_CRC_LO   = 5'd9;
  localparam logic [4:0] TAIL_LAST     = 5'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD,
    ST_CTRL,
    ST_TAIL
  } afs_state_t;

  typedef struct packed {
    logic       load_begin;
    logic       load_ctrl;
    logic       emit;
    logic       close_frame;
    afs_state_t phase;
    logic [4:0] byte_idx;
  } afs_cmd_t;

  typedef struct packed {
    logic frame_open;
    logic tail_due;
    logic out_free;
  } afs_sts_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ (t << 4);
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b0, t, 3'b0} ^ {12'b0, t[7:4]};
  endfunction

endpackage

// ----- sv/afs_in_if.sv -----
// ----------------------------------------------------------------------------
// afs_in_if
// Input channel of the frame serializer: begin and control items.
// ----------------------------------------------------------------------------
interface afs_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [63:0] time_usec;
  logic [7:0]  mode;
  logic [63:0] flags;
  logic [31:0] control_bits;

  modport source (output valid, command, time_usec, mode, flags, control_bits,
                  input ready);
  modport sink   (input valid, command, time_usec, mode, flags, control_bits,
                  output ready);
endinterface

// ----- sv/afs_out_if.sv -----
// ----------------------------------------------------------------------------
// afs_out_if
// Result channel of the frame serializer: one frame byte per item.
// ----------------------------------------------------------------------------
interface afs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_of_frame;

  modport source (output valid, frame_byte, last_of_frame, input ready);
  modport sink   (input valid, frame_byte, last_of_frame, output ready);
endinterface

// ----- sv/afs_ctrl.sv -----
// ----------------------------------------------------------------------------
// afs_ctrl
// Sequencer of the frame serializer: walks the header, control and trailer
// sections one byte per cycle whenever the output register can take a byte.
// ----------------------------------------------------------------------------
module afs_ctrl
  import afs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_command,
  output logic     in_ready,
  input  afs_sts_t sts,
  output afs_cmd_t cmd
);

  afs_state_t state_r, state_nxt;
  logic [4:0] idx_r, idx_nxt;
  logic       accept;
  logic       emit;
  logic       idx_last;

  assign accept = in_valid && (state_r == ST_IDLE);
  assign emit   = (state_r != ST_IDLE) && sts.out_free;

  always_comb begin
    unique case (state_r)
      ST_HEAD: idx_last = (idx_r == HEAD_LAST);
      ST_CTRL: idx_last = (idx_r == CTRL_LAST);
      ST_TAIL: idx_last = (idx_r == TAIL_LAST);
      default: idx_last = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (accept) begin
          if (in_command == CMD_BEGIN) begin
            state_nxt = ST_HEAD;
          end else if (sts.frame_open) begin
            state_nxt = ST_CTRL;
          end
        end
      end
      ST_HEAD, ST_CTRL, ST_TAIL: begin
        if (emit) begin
          if (idx_last) begin
            idx_nxt = '0;
            if (state_r == ST_CTRL && sts.tail_due) begin
              state_nxt = ST_TAIL;
            end else begin
              state_nxt = ST_IDLE;
            end
          end else begin
            idx_nxt = idx_r + 5'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        idx_nxt   = '0;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready        = (state_r == ST_IDLE);
    cmd.load_begin  = accept && (in_command == CMD_BEGIN);
    cmd.load_ctrl   = accept && (in_command == CMD_CONTROL) && sts.frame_open;
    cmd.emit        = emit;
    cmd.close_frame = emit && idx_last && (state_r == ST_TAIL);
    cmd.phase       = state_r;
    cmd.byte_idx    = idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// ----- sv/afs_datapath.sv -----
// ----------------------------------------------------------------------------
// afs_datapath
// Holds the configuration, the latched item fields, the running CRC and the
// output register, and forms each frame byte as the sequencer commands.
// ----------------------------------------------------------------------------
module afs_datapath
  import afs_pkg::*;
#(
  parameter int CONTROL_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic [63:0] in_time_usec,
  input  logic [7:0]  in_mode,
  input  logic [63:0] in_flags,
  input  logic [31:0] in_control_bits,
  input  afs_cmd_t    cmd,
  output afs_sts_t    sts,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [7:0]  out_frame_byte,
  output logic        out_last_of_frame
);

  localparam int         SEEN_W      = $clog2(CONTROL_COUNT + 1);
  localparam logic [7:0] PAYLOAD_LEN = 8'((8 + 4 * CONTROL_COUNT + 9) % 256);
  localparam logic [SEEN_W-1:0] SEEN_FULL = SEEN_W'(CONTROL_COUNT);

  logic [7:0]        system_id_r;
  logic [7:0]        component_id_r;
  logic [23:0]       message_id_r;
  logic [7:0]        seq_r;
  logic [15:0]       crc_r;
  logic [SEEN_W-1:0] seen_r;
  logic              frame_open_r;
  logic [7:0]        mode_r;
  logic [63:0]       flags_r;
  logic [63:0]       time_r;
  logic [31:0]       ctrl_r;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_last_r;

  logic [7:0] byte_nxt;
  logic       fold;
  logic       last;

  always_comb begin
    byte_nxt = 8'h00;
    unique case (cmd.phase)
      ST_HEAD: begin
        priority if (cmd.byte_idx == HEAD_MAGIC) byte_nxt = FRAME_MAGIC;
        else if (cmd.byte_idx == HEAD_LEN)       byte_nxt = PAYLOAD_LEN;
        else if (cmd.byte_idx == HEAD_FLAG0)     byte_nxt = 8'h00;
        else if (cmd.byte_idx == HEAD_FLAG1)     byte_nxt = 8'h00;
        else if (cmd.byte_idx == HEAD_SEQ)       byte_nxt = seq_r;
        else if (cmd.byte_idx == HEAD_SYS)       byte_nxt = system_id_r;
        else if (cmd.byte_idx == HEAD_COMP)      byte_nxt = component_id_r;
        else if (cmd.byte_idx == HEAD_MSG0)      byte_nxt = message_id_r[7:0];
        else if (cmd.byte_idx == HEAD_MSG1)      byte_nxt = message_id_r[15:8];
        else if (cmd.byte_idx == HEAD_MSG2)      byte_nxt = message_id_r[23:16];
        else                                     byte_nxt = time_r[7:0];
      end
      ST_CTRL: byte_nxt = ctrl_r[7:0];
      ST_TAIL: begin
        priority if (cmd.byte_idx == TAIL_MODE)  byte_nxt = mode_r;
        else if (cmd.byte_idx == TAIL_CRC_LO)    byte_nxt = crc_r[7:0];
        else if (cmd.byte_idx == TAIL_LAST)      byte_nxt = crc_r[15:8];
        else                                     byte_nxt = flags_r[7:0];
      end
      default: byte_nxt = 8'h00;
    endcase
  end

  // The magic byte and the two CRC bytes stay out of the checksum.
  assign fold = cmd.emit
             && !(cmd.phase == ST_HEAD && cmd.byte_idx == HEAD_MAGIC)
             && !(cmd.phase == ST_TAIL && cmd.byte_idx >= TAIL_CRC_LO);
  assign last = (cmd.phase == ST_TAIL) && (cmd.byte_idx == TAIL_LAST);

  assign sts.frame_open = frame_open_r;
  assign sts.tail_due   = (seen_r >= SEEN_FULL);
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_frame_byte    = out_byte_r;
  assign out_last_of_frame = out_last_r;

  // Control state, configuration and output handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      system_id_r    <= SYSTEM_ID_RESET;
      component_id_r <= COMPONENT_ID_RESET;
      message_id_r   <= MESSAGE_ID_RESET;
      seq_r          <= '0;
      crc_r          <= CRC_INIT;
      seen_r         <= '0;
      frame_open_r   <= 1'b0;
      mode_r         <= '0;
      flags_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SYSTEM_ID:    system_id_r    <= cfg_data[7:0];
          REG_COMPONENT_ID: component_id_r <= cfg_data[7:0];
          REG_MESSAGE_ID:   message_id_r   <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.load_begin) begin
        crc_r        <= CRC_INIT;
        seen_r       <= '0;
        frame_open_r <= 1'b1;
        mode_r       <= in_mode;
        flags_r      <= in_flags;
      end else begin
        if (cmd.load_ctrl) begin
          seen_r <= seen_r + SEEN_W'(1);
        end
        if (cmd.close_frame) begin
          seen_r       <= '0;
          frame_open_r <= 1'b0;
        end
        if (fold) begin
          crc_r <= crc_fold(crc_r, byte_nxt);
        end
        // Flag bytes leave the shift register low byte first.
        if (cmd.emit && cmd.phase == ST_TAIL && cmd.byte_idx != TAIL_MODE
            && cmd.byte_idx < TAIL_CRC_LO) begin
          flags_r <= {8'h00, flags_r[63:8]};
        end
      end

      if (cmd.emit && cmd.phase == ST_HEAD && cmd.byte_idx == HEAD_SEQ) begin
        seq_r <= seq_r + 8'd1;
      end

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload shift registers and output byte.
  always_ff @(posedge clk) begin
    if (cmd.load_begin) begin
      time_r <= in_time_usec;
    end else if (cmd.emit && cmd.phase == ST_HEAD && cmd.byte_idx >= HEAD_TIME) begin
      time_r <= {8'h00, time_r[63:8]};
    end

    if (cmd.load_ctrl) begin
      ctrl_r <= in_control_bits;
    end else if (cmd.emit && cmd.phase == ST_CTRL) begin
      ctrl_r <= {8'h00, ctrl_r[31:8]};
    end

    if (cmd.emit) begin
      out_byte_r <= byte_nxt;
      out_last_r <= last;
    end
  end

endmodule

// ----- sv/actuator_frame_serializer_crc16_core.sv -----
// ----------------------------------------------------------------------------
// actuator_frame_serializer_crc16_core
// Turns begin and control items into a byte stream of actuator frames with a
// CRC-16/MCRF4XX trailer.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes one item at a time. A begin item (command 0) latches time,
//   mode and flags and produces the 18 header bytes. A control item
//   (command 1) produces four bytes of control_bits, low byte first; the
//   last of CONTROL_COUNT controls also produces mode, eight flag bytes and
//   the CRC low and high bytes, with last_of_frame set on the final byte.
//   A control item outside an open frame is dropped without output.
//   out_ch carries one frame byte per item from a single output register.
//   Throughput: one byte per cycle while the receiver keeps ready high. The
//   byte sequencer is the limit: in_ch.ready is high only when it is idle,
//   so the next item is taken only once the last byte of the current one
//   has entered the output register. The first byte passes the sequencer
//   state register, then the output register. A stalled receiver freezes
//   the sequencer; the pending byte holds. Reset (rst_n low, synchronous)
//   restores the default ids, clears the sequence number and closes any open
//   frame. The user must keep cfg_* writes to idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module actuator_frame_serializer_crc16_core
  import afs_pkg::*;
#(
  parameter int CONTROL_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  afs_in_if.sink      in_ch,
  afs_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  afs_cmd_t cmd;
  afs_sts_t sts;

  afs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  afs_datapath #(
    .CONTROL_COUNT (CONTROL_COUNT)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_time_usec      (in_ch.time_usec),
    .in_mode           (in_ch.mode),
    .in_flags          (in_ch.flags),
    .in_control_bits   (in_ch.control_bits),
    .cmd               (cmd),
    .sts               (sts),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_frame_byte    (out_ch.frame_byte),
    .out_last_of_frame (out_ch.last_of_frame)
  );

endmodule

// ----- sv/afs_checker.sv -----
// ----------------------------------------------------------------------------
// afs_checker
// Port-level checks of the frame serializer, bound to the top level.
// ----------------------------------------------------------------------------
`include "actuator_frame_serializer_crc16_core_assert.svh"

module afs_checker
  import afs_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_command,
  input logic out_valid,
  input logic out_ready
);

  // A stalled byte stays offered.
  `AFS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // A begin item always starts a header, so the input closes right after it.
  `AFS_ASSERT_NEXT(a_begin_busy, clk, rst_n,
                   in_valid && in_ready && in_command == CMD_BEGIN, !in_ready)

  // Nothing is offered in the cycle after a reset cycle.
  `AFS_ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, !rst_n, !out_valid && in_ready)

endmodule

bind actuator_frame_serializer_crc16_core afs_checker u_afs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_command (in_ch.command),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready)
);

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the actuator frame serializer. Begin and control
// items are driven through the input channel, and every frame byte is
// compared with a cycle-free prediction of the frame, including its
// CRC-16/MCRF4XX trailer. Both channels idle at random, and the id
// registers are rewritten between phases.
// ----------------------------------------------------------------------------
module tb;
  import afs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CONTROLS     = 16;
  localparam logic [7:0] PAYLOAD_LEN  = 8'(8 + 4 * CONTROLS + 9);
  localparam logic [1:0] REG_UNUSED   = 2'd3;
  localparam int         QUIET_LIMIT  = 2000;
  localparam int         HOLD_OFF_LEN = 150;

  typedef struct packed {
    logic        command;
    logic [63:0] time_usec;
    logic [7:0]  mode;
    logic [63:0] flags;
    logic [31:0] control_bits;
  } actuator_req_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } frame_byte_t;

  localparam logic [31:0] EDGE_CONTROLS [CONTROLS] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7F80_0000,
    32'h0000_0001, 32'h7FFF_FFFF, 32'h3F80_0000, 32'hBF80_0000,
    32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000,
    32'h00FF_00FF, 32'hFF00_FF00, 32'h1234_5678, 32'h89AB_CDEF
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;

  afs_in_if  in_ch();
  afs_out_if out_ch();

  actuator_frame_serializer_crc16_core #(
    .CONTROL_COUNT(CONTROLS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Predicted serializer state and id registers.
  logic [7:0]  model_seq;
  logic [15:0] model_crc;
  logic [4:0]  model_controls;
  logic        model_open;
  logic [7:0]  model_mode;
  logic [63:0] model_flags;
  logic [7:0]  model_sys;
  logic [7:0]  model_comp;
  logic [23:0] model_msg;

  actuator_req_t pending_reqs[$];
  frame_byte_t   frame_bytes_due[$];

  actuator_req_t cur_req;
  frame_byte_t   want;
  bit            offering;
  bit            gen_open;
  bit            hold_off_wanted;
  bit            hold_off_done;
  int            hold_off_left;
  int            in_gap;
  int            out_gap;
  int            idle_odds;
  int            failures;
  int            quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Reflected form of the 0x1021 polynomial, one bit at a time.
  function automatic logic [15:0] mcrf_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
    return c;
  endfunction

  task automatic due_byte(input logic [7:0] value, input logic last, input logic fold);
    frame_bytes_due.insert(frame_bytes_due.size(), '{value, last});
    if (fold) model_crc = mcrf_update(model_crc, value);
  endtask

  task automatic due_le(input logic [63:0] v, input int count);
    for (int i = 0; i < count; i++) due_byte(v[8*i +: 8], 1'b0, 1'b1);
  endtask

  task automatic predict_frame_bytes(input actuator_req_t req);
    logic [15:0] crc_snap;
    if (req.command == CMD_BEGIN) begin
      model_mode     = req.mode;
      model_flags    = req.flags;
      model_crc      = CRC_INIT;
      model_controls = '0;
      model_open     = 1'b1;
      due_byte(FRAME_MAGIC, 1'b0, 1'b0);
      due_byte(PAYLOAD_LEN, 1'b0, 1'b1);
      due_byte(8'h00, 1'b0, 1'b1);
      due_byte(8'h00, 1'b0, 1'b1);
      due_byte(model_seq, 1'b0, 1'b1);
      model_seq = model_seq + 8'd1;
      due_byte(model_sys, 1'b0, 1'b1);
      due_byte(model_comp, 1'b0, 1'b1);
      due_le({40'd0, model_msg}, 3);
      due_le(req.time_usec, 8);
    end else if (model_open) begin
      due_le({32'd0, req.control_bits}, 4);
      model_controls = model_controls + 5'd1;
      if (model_controls >= CONTROLS) begin
        due_byte(model_mode, 1'b0, 1'b1);
        due_le(model_flags, 8);
        crc_snap = model_crc;
        due_byte(crc_snap[7:0], 1'b0, 1'b0);
        due_byte(crc_snap[15:8], 1'b1, 1'b0);
        model_open     = 1'b0;
        model_controls = '0;
      end
    end
  endtask

  function automatic logic [63:0] rand_word64();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic logic [31:0] rand_word32();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_begin(input logic [63:0] t, input logic [7:0] m, input logic [63:0] f);
    pending_reqs.insert(pending_reqs.size(), '{CMD_BEGIN, t, m, f, $urandom()});
    gen_open = 1'b1;
  endtask

  // Fields that a control item does not use carry noise.
  task automatic queue_control(input logic [31:0] bits);
    pending_reqs.insert(pending_reqs.size(),
                        '{CMD_CONTROL, {$urandom(), $urandom()}, 8'($urandom()),
                          {$urandom(), $urandom()}, bits});
  endtask

  task automatic queue_frame();
    queue_begin(rand_word64(), 8'($urandom()), rand_word64());
    for (int i = 0; i < CONTROLS; i++) queue_control(rand_word32());
    gen_open = 1'b0;
  endtask

  // Mostly complete frames; now and then a cut-short frame or controls that
  // arrive while no frame is open.
  task automatic queue_traffic(input int budget);
    int made;
    int cut;
    made = 0;
    while (made < budget) begin
      case ($urandom_range(0, 9))
        0: begin
          if (!gen_open) begin
            repeat ($urandom_range(1, 2)) queue_control(rand_word32());
          end
        end
        1: begin
          cut = $urandom_range(0, CONTROLS - 1);
          queue_begin(rand_word64(), 8'($urandom()), rand_word64());
          repeat (cut) queue_control(rand_word32());
          made += 1 + cut;
        end
        default: begin
          queue_frame();
          made += 1 + CONTROLS;
        end
      endcase
    end
    if (gen_open) queue_frame();
  endtask

  task automatic wait_until_drained();
    while (pending_reqs.size() != 0 || offering || frame_bytes_due.size() != 0)
      @(posedge clk);
  endtask

  // The block may still be busy with an item that produced nothing.
  task automatic settle();
    repeat (24) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [23:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      REG_SYSTEM_ID:    model_sys  = value[7:0];
      REG_COMPONENT_ID: model_comp = value[7:0];
      REG_MESSAGE_ID:   model_msg  = value;
      default: ;
    endcase
  endtask

  // Input driver: presents the oldest pending item until it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      offering    = 1'b0;
      in_ch.valid <= 1'b0;
    end else begin
      if (offering && in_ch.ready) begin
        predict_frame_bytes(cur_req);
        offering = 1'b0;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
          in_gap = $urandom_range(1, 6);
      end
      if (!offering) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_reqs.size() != 0) begin
          cur_req  = pending_reqs.pop_front();
          offering = 1'b1;
        end
      end
      in_ch.valid        <= offering;
      in_ch.command      <= cur_req.command;
      in_ch.time_usec    <= cur_req.time_usec;
      in_ch.mode         <= cur_req.mode;
      in_ch.flags        <= cur_req.flags;
      in_ch.control_bits <= cur_req.control_bits;
    end
  end

  // Output monitor: checks each accepted byte and paces ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (frame_bytes_due.size() == 0) begin
          failures++;
          if (failures <= 30)
            $display("%0t: unexpected byte %02h last %0b", $time,
                     out_ch.frame_byte, out_ch.last_of_frame);
        end else begin
          want = frame_bytes_due.pop_front();
          if (out_ch.frame_byte !== want.value || out_ch.last_of_frame !== want.last) begin
            failures++;
            if (failures <= 30)
              $display("%0t: expected byte %02h last %0b, got byte %02h last %0b", $time,
                       want.value, want.last, out_ch.frame_byte, out_ch.last_of_frame);
          end
        end
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_off_wanted && !hold_off_done) begin
        hold_off_done = 1'b1;
        hold_off_left = HOLD_OFF_LEN;
        out_ch.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
          out_gap = $urandom_range(1, 6);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.command      = CMD_BEGIN;
    in_ch.time_usec    = '0;
    in_ch.mode         = '0;
    in_ch.flags        = '0;
    in_ch.control_bits = '0;
    out_ch.ready       = 1'b0;
    cur_req            = '0;
    model_seq          = '0;
    model_crc          = CRC_INIT;
    model_controls     = '0;
    model_open         = 1'b0;
    model_mode         = '0;
    model_flags        = '0;
    model_sys          = SYSTEM_ID_RESET;
    model_comp         = COMPONENT_ID_RESET;
    model_msg          = MESSAGE_ID_RESET;
    idle_odds          = 6;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: a control with no open frame, an all-zero frame carrying
    // edge-value controls, then an all-ones begin left open so that the next
    // begin abandons it.
    queue_control(32'hFFFF_FFFF);
    queue_begin('0, 8'h00, '0);
    for (int i = 0; i < CONTROLS; i++) queue_control(EDGE_CONTROLS[i]);
    queue_begin('1, 8'hFF, '1);
    queue_control(32'h0000_0000);
    queue_control(32'hFFFF_FFFF);
    wait_until_drained();

    settle();
    write_register(REG_SYSTEM_ID, 24'd0);
    write_register(REG_COMPONENT_ID, 24'hFF);
    write_register(REG_MESSAGE_ID, 24'd0);
    write_register(REG_UNUSED, 24'hFF_FFFF);
    idle_odds = 3;
    queue_traffic(40);
    wait_until_drained();

    // The receiver stalls for a long stretch while items keep coming.
    settle();
    write_register(REG_SYSTEM_ID, 24'hFF);
    write_register(REG_COMPONENT_ID, 24'd0);
    write_register(REG_MESSAGE_ID, 24'hFF_FFFF);
    idle_odds       = 8;
    hold_off_wanted = 1'b1;
    queue_traffic(40);
    wait_until_drained();

    // Begins back to back, each abandoning the header-only frame before it.
    settle();
    write_register(REG_SYSTEM_ID, 24'($urandom_range(0, 255)));
    write_register(REG_COMPONENT_ID, 24'($urandom_range(0, 255)));
    write_register(REG_MESSAGE_ID, 24'($urandom()));
    idle_odds = 5;
    repeat (8) queue_begin(rand_word64(), 8'($urandom()), rand_word64());
    queue_frame();
    wait_until_drained();

    settle();
    write_register(REG_SYSTEM_ID, 24'($urandom_range(0, 255)));
    write_register(REG_COMPONENT_ID, 24'($urandom_range(0, 255)));
    write_register(REG_MESSAGE_ID, 24'($urandom()));
    idle_odds = 0;
    queue_traffic(30);
    wait_until_drained();
    repeat (30) @(posedge clk);

    if (failures == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
